FILE: design/ddr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddr_pkg: shared types and constants
// Defaults, request codes, sequencer states and fixed-point helpers for the
// Volterra predictor.
// ----------------------------------------------------------------------------
package ddr_pkg;

  localparam int unsigned PolyOrderDef   = 5;
  localparam int unsigned MemoryDepthDef = 3;
  localparam int unsigned CoefSlotsDef   = 64;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 18;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned OutW    = 24;
  localparam int unsigned AccW    = 48;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POWER,
    ST_TERM,
    ST_PAIR,
    ST_SCALE,
    ST_MAC,
    ST_DONE
  } ddr_state_t;

  // Round a Q2.30 product part to Q1.15 and saturate.
  function automatic logic signed [SampleW-1:0] round_q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [19:0] s;
    begin
      t = 35'(v) + 35'sd16384;
      s = 20'(t >>> 15);
      if (s > 20'sd32767) round_q15 = 16'sh7fff;
      else if (s < -20'sd32768) round_q15 = 16'sh8000;
      else round_q15 = s[SampleW-1:0];
    end
  endfunction

endpackage

FILE: design/ddr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddr_if: valid/ready channels
// Request channel and result channel of the Volterra predictor.
// ----------------------------------------------------------------------------
interface ddr_req_if
  import ddr_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [SampleW-1:0] sample_re;
  logic signed [SampleW-1:0] sample_im;
  logic [IndexW-1:0]         coef_index;
  logic signed [CoefW-1:0]   coef_re;
  logic signed [CoefW-1:0]   coef_im;

  modport source (output valid, req_type, sample_re, sample_im, coef_index, coef_re,
                  coef_im, input ready);
  modport sink (input valid, req_type, sample_re, sample_im, coef_index, coef_re,
                coef_im, output ready);
endinterface

interface ddr_res_if
  import ddr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] out_re;
  logic signed [OutW-1:0] out_im;

  modport source (output valid, out_re, out_im, input ready);
  modport sink (input valid, out_re, out_im, output ready);
endinterface

FILE: design/ddr_volterra_predictor_core.sv
`timescale 1ns / 1ps
// A coefficient word or a history-filling sample is stored directly in the idle state.
// A full sample takes (K-1) power steps, then per basis term a fetch step, pair or scale
// steps as needed and a multiply-accumulate step, and one output step.
// The single shared complex multiplier does every product; one word is in work at a time.
// Reset (rst, synchronous) clears history, fill count and handshake state; the
// coefficient memory holds no reset value.
// ----------------------------------------------------------------------------
// ddr_volterra_predictor_core: DDR Volterra model evaluator
// A sequencer drives one shared complex multiplier through power, basis and
// multiply-accumulate steps, then rounds and saturates the sum.
// ----------------------------------------------------------------------------
module ddr_volterra_predictor_core
  import ddr_pkg::*;
#(
  parameter int unsigned POLY_ORDER   = PolyOrderDef,
  parameter int unsigned MEMORY_DEPTH = MemoryDepthDef,
  parameter int unsigned COEF_SLOTS   = CoefSlotsDef
) (
  input logic     clk,
  input logic     rst,
  ddr_req_if.sink req,
  ddr_res_if.source res
);

  localparam int unsigned KW   = $clog2(POLY_ORDER + 1);
  localparam int unsigned MW   = $clog2(MEMORY_DEPTH + 1);
  localparam int unsigned SW   = $clog2(COEF_SLOTS);
  localparam int unsigned SLTW = 9;

  typedef logic signed [SampleW-1:0] s16_t;

  ddr_state_t state, state_next;

  // Coefficient memory.
  logic signed [2*CoefW-1:0] coef_mem [COEF_SLOTS];
  logic signed [2*CoefW-1:0] coef_q;

  s16_t hist_re [MEMORY_DEPTH];
  s16_t hist_im [MEMORY_DEPTH];
  logic [MW-1:0] fill;
  s16_t pw_re [POLY_ORDER+1];
  s16_t pw_im [POLY_ORDER+1];
  s16_t b_re, b_im;

  logic [KW-1:0] k;
  logic [MW-1:0] m1, m2;
  logic [1:0]    grp;
  logic [SLTW-1:0] slot;
  logic signed [AccW-1:0] acc_re, acc_im;
  logic signed [OutW-1:0] o_re, o_im;
  logic o_valid;

  // Shared complex multiplier: a (Q1.15 or coef) times b (Q1.15).
  logic signed [CoefW-1:0]  ma_re, ma_im;
  s16_t                     mb_re, mb_im;
  logic signed [CoefW+SampleW:0] mp_re, mp_im;
  s16_t r_re, r_im;

  logic busy_ok;
  assign busy_ok = (state == ST_IDLE) && !o_valid;
  assign req.ready = busy_ok;
  assign res.valid = o_valid;
  assign res.out_re = o_re;
  assign res.out_im = o_im;

  // Operand selection for the shared multiplier.
  always_comb begin
    ma_re = CoefW'(pw_re[1]);
    ma_im = CoefW'(pw_im[1]);
    mb_re = pw_re[k-KW'(1)];
    mb_im = pw_im[k-KW'(1)];
    case (state)
      ST_POWER: begin
        ma_re = CoefW'(pw_re[k-KW'(1)]);
        ma_im = CoefW'(pw_im[k-KW'(1)]);
        mb_re = pw_re[1];
        mb_im = pw_im[1];
      end
      ST_PAIR: begin
        ma_re = CoefW'(hist_re[m1-MW'(1)]);
        ma_im = CoefW'(hist_im[m1-MW'(1)]);
        mb_re = hist_re[m2-MW'(1)];
        mb_im = hist_im[m2-MW'(1)];
      end
      ST_SCALE: begin
        ma_re = CoefW'(b_re);
        ma_im = CoefW'(b_im);
        mb_re = (grp == 2'd1) ? pw_re[k-KW'(1)] : pw_re[k-KW'(2)];
        mb_im = (grp == 2'd1) ? pw_im[k-KW'(1)] : pw_im[k-KW'(2)];
      end
      ST_MAC: begin
        ma_re = coef_q[2*CoefW-1:CoefW];
        ma_im = coef_q[CoefW-1:0];
        mb_re = b_re;
        mb_im = b_im;
      end
      default: ;
    endcase
  end

  assign mp_re = (CoefW+SampleW+1)'(ma_re * mb_re) - (CoefW+SampleW+1)'(ma_im * mb_im);
  assign mp_im = (CoefW+SampleW+1)'(ma_re * mb_im) + (CoefW+SampleW+1)'(ma_im * mb_re);
  assign r_re = round_q15(34'(mp_re));
  assign r_im = round_q15(34'(mp_im));

  // Position bookkeeping: what comes after the current term.
  logic last_m, last_k, last_m2;
  assign last_m  = (m1 == MW'(MEMORY_DEPTH));
  assign last_m2 = (m2 == MW'(MEMORY_DEPTH));
  assign last_k  = (k == KW'(POLY_ORDER));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (req.valid && busy_ok && req.req_type == REQ_SAMPLE &&
            fill == MW'(MEMORY_DEPTH))
          state_next = (POLY_ORDER > 1) ? ST_POWER : ST_TERM;
      ST_POWER: if (last_k) state_next = ST_TERM;
      ST_TERM: begin
        if (grp == 2'd2) state_next = ST_PAIR;
        else if (grp == 2'd1 && k > KW'(1)) state_next = ST_SCALE;
        else state_next = ST_MAC;
      end
      ST_PAIR:  state_next = (k > KW'(2)) ? ST_SCALE : ST_MAC;
      ST_SCALE: state_next = ST_MAC;
      ST_MAC: begin
        if (grp == 2'd0) state_next = last_k ? ST_TERM : ST_TERM;
        else if (grp == 2'd1) state_next = (last_k && last_m) ? ST_DONE : ST_TERM;
        else state_next = (last_k && last_m && last_m2) ? ST_DONE : ST_TERM;
        if (grp == 2'd1 && last_k && last_m && POLY_ORDER >= 2) state_next = ST_TERM;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Round the Q.28 sum to Q9.15 and saturate to the output width.
  function automatic logic signed [OutW-1:0] sat_out(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    begin
      t = (v + AccW'(4096)) >>> 13;
      if (t > AccW'(8388607)) sat_out = 24'sh7fffff;
      else if (t < -AccW'(8388608)) sat_out = 24'sh800000;
      else sat_out = t[OutW-1:0];
    end
  endfunction

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fill    <= '0;
      o_valid <= 1'b0;
      for (int i = 0; i < MEMORY_DEPTH; i++) begin
        hist_re[i] <= '0;
        hist_im[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (res.valid && res.ready) o_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.valid && busy_ok) begin
            if (req.req_type == REQ_COEF) begin
              if (32'(req.coef_index) < COEF_SLOTS)
                coef_mem[SW'(req.coef_index)] <= {req.coef_re, req.coef_im};
            end else if (fill != MW'(MEMORY_DEPTH)) begin
              for (int i = MEMORY_DEPTH - 1; i > 0; i--) begin
                hist_re[i] <= hist_re[i-1];
                hist_im[i] <= hist_im[i-1];
              end
              hist_re[0] <= req.sample_re;
              hist_im[0] <= req.sample_im;
              fill <= fill + MW'(1);
            end else begin
              pw_re[1] <= req.sample_re;
              pw_im[1] <= req.sample_im;
              k <= KW'(2);
              grp <= 2'd0;
              slot <= '0;
              acc_re <= '0;
              acc_im <= '0;
              if (POLY_ORDER <= 1) k <= KW'(1);
            end
          end
        end
        ST_POWER: begin
          pw_re[k] <= r_re;
          pw_im[k] <= r_im;
          if (last_k) k <= KW'(1);
          else k <= k + KW'(1);
        end
        ST_TERM: begin
          // Fetch the coefficient and pick the plain basis.
          coef_q <= (32'(slot) < COEF_SLOTS) ? coef_mem[slot[SW-1:0]] : '0;
          if (grp == 2'd0) begin
            b_re <= pw_re[k];
            b_im <= pw_im[k];
          end else begin
            b_re <= hist_re[m1-MW'(1)];
            b_im <= hist_im[m1-MW'(1)];
          end
        end
        ST_PAIR: begin
          b_re <= r_re;
          b_im <= r_im;
        end
        ST_SCALE: begin
          b_re <= r_re;
          b_im <= r_im;
        end
        ST_MAC: begin
          acc_re <= acc_re + AccW'(mp_re);
          acc_im <= acc_im + AccW'(mp_im);
          slot <= slot + SLTW'(1);
          // Advance the loop indices.
          case (grp)
            2'd0: begin
              if (last_k) begin
                grp <= 2'd1; k <= KW'(1); m1 <= MW'(1);
              end else k <= k + KW'(1);
            end
            2'd1: begin
              if (!last_m) m1 <= m1 + MW'(1);
              else begin
                m1 <= MW'(1);
                if (last_k) begin
                  grp <= 2'd2; k <= KW'(2); m2 <= MW'(1);
                end else k <= k + KW'(1);
              end
            end
            default: begin
              if (!last_m2) m2 <= m2 + MW'(1);
              else if (!last_m) begin
                m1 <= m1 + MW'(1); m2 <= m1 + MW'(1);
              end else begin
                m1 <= MW'(1); m2 <= MW'(1); k <= k + KW'(1);
              end
            end
          endcase
        end
        ST_DONE: begin
          for (int i = MEMORY_DEPTH - 1; i > 0; i--) begin
            hist_re[i] <= hist_re[i-1];
            hist_im[i] <= hist_im[i-1];
          end
          hist_re[0] <= pw_re[1];
          hist_im[0] <= pw_im[1];
          o_re <= sat_out(acc_re);
          o_im <= sat_out(acc_im);
          o_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/ddr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddr_checker: port-level checks
// Watches the request and result channels of the predictor core.
// ----------------------------------------------------------------------------
module ddr_checker
  import ddr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [OutW-1:0] out_re
);

  // A result word holds until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_re)) else $error("result dropped");

  // No new request is taken while a result waits.
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready) else $error("accept during pending result");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !res_valid) else $error("valid after reset");

  // A result appears only after the block was busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(req_ready)) else $error("result out of nowhere");

endmodule

bind ddr_volterra_predictor_core ddr_checker u_ddr_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .out_re(res.out_re)
);
